// ===== hdl/sobelh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobelh_pkg - shared types and constants of the horizontal Sobel filter
// Pixel and size widths, register indexes and the per-item control word
// that travels from the counter stage to the window stage.
// ---------------------------------------------------------------------------
package sobelh_pkg;

  localparam int PIX_W      = 8;             // grayscale pixel width
  localparam int LINE_W     = 2 * PIX_W;     // line memory entry: {upper, lower}
  localparam int CFG_W      = 10;            // size register width
  localparam int CFG_IDX_W  = 2;             // register index width
  localparam int ROW_CNT_W  = 10;            // input row counter, wraps at 1024
  localparam int SUM_W      = PIX_W + 2;     // 1,2,1 row sum width
  localparam int RST_SIZE   = 512;           // reset value of both size registers

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Control word for one accepted item
  typedef struct packed {
    logic emit;        // item produces an output pixel
    logic last;        // output pixel is the final one of the image
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } item_ctl_t;

endpackage

// ===== hdl/sobel_horizontal_edge_filter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobel_horizontal_edge_filter_unit - streaming 3x3 horizontal Sobel filter
// Raster-order grayscale pixels in, clamped (bottom 1,2,1 - top 1,2,1)
// responses out, one row plus one pixel behind the input stream.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tdata = pixel_in, tuser = flush
//  m_*       out        m_tvalid/m_tready   tdata = edge_value, tlast = last_of_image
//  cfg_*     in         cfg_valid/cfg_ready index 0 = image_width, 1 = image_height
//
//  One item per clock sustained while results are taken. An item is read from
//  the line memory at its accept edge; when it leaves the hold stage the window
//  and the memory are updated and its result enters the output register.
//  Synchronous reset clears counters, window and valids; the line memory is
//  not cleared and needs no clearing pass.
//  s_tready is low during reset, and otherwise drops only while an item that
//  produces a result waits on a full output register that is not being taken.
// ---------------------------------------------------------------------------
module sobel_horizontal_edge_filter_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sobelh_pkg::PIX_W-1:0]     s_tdata,    // [7:0] pixel_in
  input  logic                             s_tuser,    // [0] flush
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sobelh_pkg::PIX_W-1:0]     m_tdata,    // [7:0] edge_value
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sobelh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobelh_pkg::CFG_W-1:0]     cfg_data
);
  import sobelh_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE;
  localparam int RST_H = (RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE;

  // Sizes and position counters
  logic [WW-1:0]        img_w;
  logic [HW-1:0]        img_h;
  logic [ROW_CNT_W-1:0] row_cnt;
  logic [AW-1:0]        col_cnt;
  logic [HW-1:0]        out_row;
  logic [AW-1:0]        out_col;

  logic [WW-1:0] cfg_w_clamped;
  logic [HW-1:0] cfg_h_clamped;
  logic          cfg_fire;
  logic          in_fire;
  logic          in_row_ok;
  logic          col_wrap;
  logic          out_col_end;
  logic          out_row_end;
  item_ctl_t     ctl_a;

  // Item held for the window stage
  logic              p1_valid;
  item_ctl_t         p1_ctl;
  logic [PIX_W-1:0]  p1_pix;
  logic [AW-1:0]     p1_addr;
  logic              p1_retire;

  // Window columns of the top and bottom rows
  logic [PIX_W-1:0]  top_w1, top_w2, bot_w1, bot_w2;
  logic [LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]  line_top, line_mid;
  logic [SUM_W-1:0]  tap_a, tap_b, tap_c, tap_g, tap_h, tap_i;
  logic [SUM_W-1:0]  sum_pos, sum_neg, sum_diff;
  logic [PIX_W-1:0]  edge_val;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = s_tvalid && s_tready;

  // Saturate written sizes to 1..MAX
  always_comb begin
    if (cfg_data == '0) begin
      cfg_w_clamped = WW'(1);
      cfg_h_clamped = HW'(1);
    end else begin
      cfg_w_clamped = (32'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
      cfg_h_clamped = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  // Decide output and border flags for the item at the input
  always_comb begin
    in_row_ok   = (row_cnt >= ROW_CNT_W'(2)) ||
                  ((row_cnt == ROW_CNT_W'(1)) && (col_cnt != '0));
    col_wrap    = (WW'(col_cnt) + WW'(1)) >= img_w;
    out_col_end = (WW'(out_col) + WW'(1)) == img_w;
    out_row_end = (out_row + HW'(1)) == img_h;
    ctl_a.emit      = in_row_ok && (out_row < img_h);
    ctl_a.last      = ctl_a.emit && out_row_end && out_col_end;
    ctl_a.has_up    = out_row != '0;
    ctl_a.has_down  = (out_row + HW'(1)) < img_h;
    ctl_a.has_left  = out_col != '0;
    ctl_a.has_right = (WW'(out_col) + WW'(1)) < img_w;
  end

  // Advance counters; a write to either size register starts a new image
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= WW'(RST_W);
      img_h   <= HW'(RST_H);
      row_cnt <= '0;
      col_cnt <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
        row_cnt <= '0;
        col_cnt <= '0;
        out_row <= '0;
        out_col <= '0;
      end
      if (cfg_index == REG_IMAGE_WIDTH) begin
        img_w <= cfg_w_clamped;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        img_h <= cfg_h_clamped;
      end
    end else if (in_fire) begin
      if (ctl_a.last) begin
        row_cnt <= '0;
        col_cnt <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (ctl_a.emit) begin
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + HW'(1);
          end else begin
            out_col <= out_col + AW'(1);
          end
        end
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + ROW_CNT_W'(1);
        end else begin
          col_cnt <= col_cnt + AW'(1);
        end
      end
    end
  end

  // Hold the item while its memory read completes and its result waits for the output register
  assign p1_retire = p1_valid && (!p1_ctl.emit || !m_tvalid || m_tready);
  assign s_tready  = !rst && (!p1_valid || p1_retire);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (in_fire) begin
      p1_valid <= 1'b1;
    end else if (p1_retire) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_ctl  <= ctl_a;
      p1_pix  <= s_tuser ? '0 : s_tdata;
      p1_addr <= col_cnt;
    end
  end

  sobelh_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (col_cnt),
    .rd_data (line_rd),
    .wr_en   (p1_retire),
    .wr_addr (p1_addr),
    .wr_data ({line_mid, p1_pix})
  );

  assign line_top = line_rd[LINE_W-1:PIX_W];
  assign line_mid = line_rd[PIX_W-1:0];

  // Shift the window; the new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      top_w1 <= '0;
      top_w2 <= '0;
      bot_w1 <= '0;
      bot_w2 <= '0;
    end else if (p1_retire) begin
      top_w1 <= top_w2;
      top_w2 <= line_top;
      bot_w1 <= bot_w2;
      bot_w2 <= p1_pix;
    end
  end

  // Mask border taps and form the clamped response
  always_comb begin
    tap_a = (p1_ctl.has_up && p1_ctl.has_left)    ? SUM_W'(top_w1)   : '0;
    tap_b = p1_ctl.has_up                          ? SUM_W'(top_w2)   : '0;
    tap_c = (p1_ctl.has_up && p1_ctl.has_right)   ? SUM_W'(line_top) : '0;
    tap_g = (p1_ctl.has_down && p1_ctl.has_left)  ? SUM_W'(bot_w1)   : '0;
    tap_h = p1_ctl.has_down                        ? SUM_W'(bot_w2)   : '0;
    tap_i = (p1_ctl.has_down && p1_ctl.has_right) ? SUM_W'(p1_pix)   : '0;
    sum_pos  = tap_g + (tap_h << 1) + tap_i;
    sum_neg  = tap_a + (tap_b << 1) + tap_c;
    sum_diff = sum_pos - sum_neg;
    if (sum_pos <= sum_neg) begin
      edge_val = '0;
    end else if (sum_diff > SUM_W'(PIX_MAX)) begin
      edge_val = PIX_MAX;
    end else begin
      edge_val = sum_diff[PIX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p1_retire && p1_ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_retire && p1_ctl.emit) begin
      m_tdata <= edge_val;
      m_tlast <= p1_ctl.last;
    end
  end

endmodule

// ===== hdl/sobelh_line_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobelh_line_mem - dual line store
// One synchronous memory holding both previous rows per column, with a
// registered read port and write-to-read forwarding on a same-address clash.
// ---------------------------------------------------------------------------
module sobelh_line_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [sobelh_pkg::LINE_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [sobelh_pkg::LINE_W-1:0] wr_data
);
  import sobelh_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] byp_q;
  logic              byp_sel;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp_q <= wr_data;
    end
  end

  // Track a read that hits the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_sel <= 1'b0;
    end else if (rd_en) begin
      byp_sel <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_sel ? byp_q : rd_q;

endmodule

// ===== hdl/sobelh_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sobelh_checker - port-level checks of the horizontal Sobel filter
// Watches reset behavior, output holding and the configuration port.
// ---------------------------------------------------------------------------
module sobelh_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sobelh_pkg::PIX_W-1:0] m_tdata,
  input logic                         m_tlast,
  input logic                         cfg_ready
);
  import sobelh_pkg::*;

  // No result can come out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result shown too soon after reset");

  // Input side opens as soon as reset is released
  a_ready_after_reset: assert property (@(posedge clk)
    (rst ##1 !rst) |-> s_tready)
    else $error("input not ready after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // Register writes are never refused
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port refused a write");

endmodule

bind sobel_horizontal_edge_filter_unit sobelh_checker u_sobelh_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);
